// File: rtl/core/nmea_rmc_time_parser_unit_defines.svh
// Assertion macros shared by the RTL of the RMC time parser.
`ifndef NMEA_RMC_TIME_PARSER_UNIT_DEFINES_SVH
`define NMEA_RMC_TIME_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrtp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NRTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrtp: next-cycle check failed");

`endif

// File: rtl/core/nrtp_pkg.sv
package nrtp_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;

  localparam int US_DIGITS = 6;

  localparam logic [31:0] DAY_SECONDS      = 32'd86400;
  localparam logic [20:0] CIVIL_DAY_OFFSET = 21'd719468;

  // Result fields, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] update_count;
    logic [29:0] frac_nanoseconds;
    logic [19:0] frac_microseconds;
    logic [31:0] epoch_seconds;
  } result_t;

  // Characters of the sentence header "$GPRMC".
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Two-digit decimal accumulate; the value never exceeds 99.
  function automatic logic [6:0] acc2(input logic [6:0] v, input logic [3:0] d);
    logic [9:0] t;
    t = 10'(v) * 10'd10 + 10'(d);
    return t[6:0];
  endfunction

  // Weight of a fraction digit in nanoseconds.
  function automatic logic [29:0] pow_ns(input logic [3:0] idx);
    logic [29:0] w;
    case (idx)
      4'd0:    w = 30'd100000000;
      4'd1:    w = 30'd10000000;
      4'd2:    w = 30'd1000000;
      4'd3:    w = 30'd100000;
      4'd4:    w = 30'd10000;
      4'd5:    w = 30'd1000;
      4'd6:    w = 30'd100;
      4'd7:    w = 30'd10;
      4'd8:    w = 30'd1;
      default: w = 30'd0;
    endcase
    return w;
  endfunction

  // Weight of a fraction digit in microseconds.
  function automatic logic [19:0] pow_us(input logic [3:0] idx);
    logic [19:0] w;
    case (idx)
      4'd0:    w = 20'd100000;
      4'd1:    w = 20'd10000;
      4'd2:    w = 20'd1000;
      4'd3:    w = 20'd100;
      4'd4:    w = 20'd10;
      4'd5:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

  // Days from March 1 to the first of the month, in a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Exact floor(x / 25) for any 10-bit x, by reciprocal multiplication.
  function automatic logic [5:0] div25(input logic [9:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'd5243;
    return prod[22:17];
  endfunction

endpackage

// File: rtl/core/nmea_rmc_time_parser_unit.sv
// NMEA RMC time parser. One ASCII character enters per transfer on the in_ channel and
// the block sustains one character per clock except when in_tready drops. CR or LF
// closes a line; a line that starts with $GPRMC, has at least ten comma fields, status A, a
// valid HHMMSS[.fff] time and a DDMMYY date with month 1..12 produces one result transfer with
// Unix seconds (year BASE_YEAR+YY, day/hour/minute/second added linearly), the fraction of a
// second truncated to microseconds and nanoseconds (first FRAC_DIGITS digits), and an update
// count that rises by two for each result. After the line end is taken, one register holds the
// day count and time of day, and the next multiplies days by 86400.
// Both result registers may hold a result while the output is stalled; in_tready drops only
// when both are occupied. The checksum field is not checked.
`include "nmea_rmc_time_parser_unit_defines.svh"

module nmea_rmc_time_parser_unit #(
  parameter int BASE_YEAR   = 2000,
  parameter int FRAC_DIGITS = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // [31:0] epoch_seconds, [51:32] frac_microseconds,
                                   // [81:52] frac_nanoseconds, [113:82] update_count, rest 0
);
  import nrtp_pkg::*;

  localparam int US_LIMIT = (FRAC_DIGITS < US_DIGITS) ? FRAC_DIGITS : US_DIGITS;

  // Line parser state.
  logic        line_nonempty_r, line_nonempty_nxt;
  logic        prefix_ok_r, prefix_ok_nxt;
  logic [3:0]  field_index_r, field_index_nxt;
  logic [3:0]  field_char_pos_r, field_char_pos_nxt;
  logic        status_active_r, status_active_nxt;
  logic [6:0]  hour_value_r, hour_value_nxt;
  logic [6:0]  minute_value_r, minute_value_nxt;
  logic [6:0]  second_value_r, second_value_nxt;
  logic [29:0] fraction_ns_r, fraction_ns_nxt;
  logic [19:0] fraction_us_r, fraction_us_nxt;
  logic [3:0]  fraction_digits_r, fraction_digits_nxt;
  logic [6:0]  day_value_r, day_value_nxt;
  logic [6:0]  month_value_r, month_value_nxt;
  logic [6:0]  year_value_r, year_value_nxt;
  logic        bad_format_r, bad_format_nxt;
  logic [31:0] sample_counter_r, sample_counter_nxt;

  // First result stage: day count and time of day.
  logic               s1_valid_r;
  logic signed [17:0] s1_days_r;
  logic [18:0]        s1_tod_r;
  logic [19:0]        s1_us_r;
  logic [29:0]        s1_ns_r;
  logic [31:0]        s1_count_r;

  // Output register.
  logic    out_valid_r;
  result_t out_data_r;

  logic       in_fire, is_eol, is_comma, is_dig, emit, out_load;
  logic [7:0] rx;
  logic [3:0] dval;
  logic       close_prefix_bad, close_bad;

  logic [11:0] year_full;
  logic [9:0]  year_q4;
  logic [5:0]  year_q100, year_q400;
  logic [20:0] days_sum;
  logic [20:0] days_total;
  logic [18:0] tod;
  logic [31:0] days_ext;

  assign rx       = in_tdata;
  assign dval     = rx[3:0];
  assign is_eol   = (rx == CH_CR) || (rx == CH_LF);
  assign is_comma = (rx == CH_COMMA);
  assign is_dig   = is_digit(rx);

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  // Checks made when a field closes, at a comma or at the line end.
  assign close_prefix_bad = (field_index_r == 4'd0) && (field_char_pos_r < 4'd6);
  assign close_bad = ((field_index_r == 4'd1) &&
                      ((field_char_pos_r < 4'd6) || (field_char_pos_r == 4'd7))) ||
                     ((field_index_r == 4'd9) && (field_char_pos_r != 4'd6));

  assign emit = in_fire && is_eol && line_nonempty_r && prefix_ok_r && !close_prefix_bad &&
                (field_index_r >= 4'd9) && status_active_r && !bad_format_r && !close_bad &&
                (month_value_r >= 7'd1) && (month_value_r <= 7'd12);

  // Days since 1970-01-01 of the date, counted from a March-based year.
  always_comb begin
    year_full = 12'(BASE_YEAR) + 12'(year_value_r) -
                ((month_value_r <= 7'd2) ? 12'd1 : 12'd0);
    year_q4   = year_full[11:2];
    year_q100 = div25(year_q4);
    year_q400 = div25({2'b00, year_full[11:4]});
    days_sum  = 21'(year_full) * 21'd365 + 21'(year_q4) + 21'(year_q400) +
                21'(month_offset(month_value_r[3:0])) - 21'(year_q100);
    // Day zero of the month gives minus one day; the wrap is kept modulo the word width.
    days_total = days_sum - CIVIL_DAY_OFFSET + 21'(day_value_r) - 21'd1;
    tod = 19'(hour_value_r) * 19'd3600 + 19'(minute_value_r) * 19'd60 + 19'(second_value_r);
  end

  always_comb begin
    line_nonempty_nxt   = line_nonempty_r;
    prefix_ok_nxt       = prefix_ok_r;
    field_index_nxt     = field_index_r;
    field_char_pos_nxt  = field_char_pos_r;
    status_active_nxt   = status_active_r;
    hour_value_nxt      = hour_value_r;
    minute_value_nxt    = minute_value_r;
    second_value_nxt    = second_value_r;
    fraction_ns_nxt     = fraction_ns_r;
    fraction_us_nxt     = fraction_us_r;
    fraction_digits_nxt = fraction_digits_r;
    day_value_nxt       = day_value_r;
    month_value_nxt     = month_value_r;
    year_value_nxt      = year_value_r;
    bad_format_nxt      = bad_format_r;
    sample_counter_nxt  = sample_counter_r;

    if (in_fire) begin
      if (is_eol) begin
        if (emit) begin
          sample_counter_nxt = sample_counter_r + 32'd2;
        end
        line_nonempty_nxt   = 1'b0;
        prefix_ok_nxt       = 1'b1;
        field_index_nxt     = 4'd0;
        field_char_pos_nxt  = 4'd0;
        status_active_nxt   = 1'b0;
        hour_value_nxt      = 7'd0;
        minute_value_nxt    = 7'd0;
        second_value_nxt    = 7'd0;
        fraction_ns_nxt     = 30'd0;
        fraction_us_nxt     = 20'd0;
        fraction_digits_nxt = 4'd0;
        day_value_nxt       = 7'd0;
        month_value_nxt     = 7'd0;
        year_value_nxt      = 7'd0;
        bad_format_nxt      = 1'b0;
      end else if (is_comma) begin
        line_nonempty_nxt = 1'b1;
        if (close_prefix_bad) begin
          prefix_ok_nxt = 1'b0;
        end
        if (close_bad) begin
          bad_format_nxt = 1'b1;
        end
        if (field_index_r != 4'd15) begin
          field_index_nxt = field_index_r + 4'd1;
        end
        field_char_pos_nxt = 4'd0;
        // Entering the status field starts it as not active.
        if (field_index_r == 4'd1) begin
          status_active_nxt = 1'b0;
        end
      end else begin
        line_nonempty_nxt = 1'b1;
        if ((field_index_r == 4'd0) && (field_char_pos_r < 4'd6) &&
            (rx != hdr_char(field_char_pos_r[2:0]))) begin
          prefix_ok_nxt = 1'b0;
        end
        if (field_index_r == 4'd1) begin
          if (field_char_pos_r < 4'd6) begin
            if (!is_dig) begin
              bad_format_nxt = 1'b1;
            end else if (field_char_pos_r < 4'd2) begin
              hour_value_nxt = acc2(hour_value_r, dval);
            end else if (field_char_pos_r < 4'd4) begin
              minute_value_nxt = acc2(minute_value_r, dval);
            end else begin
              second_value_nxt = acc2(second_value_r, dval);
            end
          end else if (field_char_pos_r == 4'd6) begin
            if (rx != CH_DOT) begin
              bad_format_nxt = 1'b1;
            end
          end else if (!is_dig) begin
            bad_format_nxt = 1'b1;
          end else begin
            if (fraction_digits_r < 4'(FRAC_DIGITS)) begin
              fraction_ns_nxt = fraction_ns_r + 30'(pow_ns(fraction_digits_r) * 30'(dval));
            end
            // The microsecond sum keeps only the digits that survive truncation.
            if (fraction_digits_r < 4'(US_LIMIT)) begin
              fraction_us_nxt = fraction_us_r + 20'(pow_us(fraction_digits_r) * 20'(dval));
            end
            if (fraction_digits_r != 4'd15) begin
              fraction_digits_nxt = fraction_digits_r + 4'd1;
            end
          end
        end
        if (field_index_r == 4'd2) begin
          status_active_nxt = (field_char_pos_r == 4'd0) && (rx == CH_A);
        end
        if ((field_index_r == 4'd9) && (field_char_pos_r < 4'd6)) begin
          if (!is_dig) begin
            bad_format_nxt = 1'b1;
          end else if (field_char_pos_r < 4'd2) begin
            day_value_nxt = acc2(day_value_r, dval);
          end else if (field_char_pos_r < 4'd4) begin
            month_value_nxt = acc2(month_value_r, dval);
          end else begin
            year_value_nxt = acc2(year_value_r, dval);
          end
        end
        if (field_char_pos_r != 4'd15) begin
          field_char_pos_nxt = field_char_pos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_nonempty_r   <= 1'b0;
      prefix_ok_r       <= 1'b1;
      field_index_r     <= 4'd0;
      field_char_pos_r  <= 4'd0;
      status_active_r   <= 1'b0;
      hour_value_r      <= 7'd0;
      minute_value_r    <= 7'd0;
      second_value_r    <= 7'd0;
      fraction_ns_r     <= 30'd0;
      fraction_us_r     <= 20'd0;
      fraction_digits_r <= 4'd0;
      day_value_r       <= 7'd0;
      month_value_r     <= 7'd0;
      year_value_r      <= 7'd0;
      bad_format_r      <= 1'b0;
      sample_counter_r  <= 32'd0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      line_nonempty_r   <= line_nonempty_nxt;
      prefix_ok_r       <= prefix_ok_nxt;
      field_index_r     <= field_index_nxt;
      field_char_pos_r  <= field_char_pos_nxt;
      status_active_r   <= status_active_nxt;
      hour_value_r      <= hour_value_nxt;
      minute_value_r    <= minute_value_nxt;
      second_value_r    <= second_value_nxt;
      fraction_ns_r     <= fraction_ns_nxt;
      fraction_us_r     <= fraction_us_nxt;
      fraction_digits_r <= fraction_digits_nxt;
      day_value_r       <= day_value_nxt;
      month_value_r     <= month_value_nxt;
      year_value_r      <= year_value_nxt;
      bad_format_r      <= bad_format_nxt;
      sample_counter_r  <= sample_counter_nxt;
      if (emit) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign days_ext = {{14{s1_days_r[17]}}, s1_days_r};

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_days_r  <= days_total[17:0];
      s1_tod_r   <= tod;
      s1_us_r    <= fraction_us_r;
      s1_ns_r    <= fraction_ns_r;
      s1_count_r <= sample_counter_nxt;
    end
    if (out_load) begin
      out_data_r.pad               <= 6'd0;
      out_data_r.update_count      <= s1_count_r;
      out_data_r.frac_nanoseconds  <= s1_ns_r;
      out_data_r.frac_microseconds <= s1_us_r;
      out_data_r.epoch_seconds     <= 32'(days_ext * DAY_SECONDS) + 32'(s1_tod_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `NRTP_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !in_tready, s1_valid_r && out_valid_r)
  `NRTP_ASSERT_NEXT(a_emit_fills_stage, clk, rst_n, emit, s1_valid_r)
  `NRTP_ASSERT_NEXT(a_count_by_two, clk, rst_n, emit,
                    sample_counter_r == $past(sample_counter_r) + 32'd2)
  `NRTP_ASSERT_NEXT(a_line_end_clears, clk, rst_n, in_fire && is_eol,
                    !line_nonempty_r && (field_index_r == 4'd0) && prefix_ok_r)

endmodule
